// File: rtl/core/array_list_shift_insert_remove_defines.svh
// Assertion macros used by the list block's top-level RTL file.
`ifndef ARRAY_LIST_SHIFT_INSERT_REMOVE_DEFINES_SVH
`define ARRAY_LIST_SHIFT_INSERT_REMOVE_DEFINES_SVH

// Checks that cond holds in the same cycle as trig.
`define ALSI_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("list block check failed");

// Checks that cond holds in the cycle after trig.
`define ALSI_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("list block check failed");

`endif

// File: rtl/core/alsi_pkg.sv
// Package with the list block's constants, command and status codes, and cell control type.
package alsi_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int ENTRY_W = 7;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP_SZ  = 8;
    localparam int NUM_GRP = (DEPTH + GRP_SZ - 1) / GRP_SZ;

    typedef enum logic [2:0] {
        CMD_PUSH_TAIL = 3'd0,
        CMD_POP_TAIL  = 3'd1,
        CMD_INS_HEAD  = 3'd2,
        CMD_POP_HEAD  = 3'd3,
        CMD_INS_POS   = 3'd4
    } t_command;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        logic                     ins;
        logic                     pop_head;
        logic                     pop_tail;
        logic [CNT_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

// File: rtl/core/alsi_cell.sv
// One list cell: holds one entry and shifts, loads or holds it from its neighbors.
module alsi_cell (
    input  logic                              i_clk,
    input  logic [alsi_pkg::IDX_W-1:0]        i_index,
    input  alsi_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [alsi_pkg::DATA_W-1:0] i_lower_value,
    input  logic signed [alsi_pkg::DATA_W-1:0] i_upper_value,
    output logic signed [alsi_pkg::DATA_W-1:0] o_value,
    output logic signed [alsi_pkg::DATA_W-1:0] o_sel_value
);

    logic signed [alsi_pkg::DATA_W-1:0] r_value;
    logic signed [alsi_pkg::DATA_W-1:0] n_value;
    logic [alsi_pkg::CNT_W-1:0]         w_idx;
    logic [alsi_pkg::CNT_W-1:0]         w_idx_p1;
    logic                               w_sel;

    assign w_idx    = alsi_pkg::CNT_W'(i_index);
    assign w_idx_p1 = w_idx + alsi_pkg::CNT_W'(1);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (w_idx == i_ctrl.pos) begin
                n_value = i_ctrl.data;
            end else if ((w_idx > i_ctrl.pos) && (w_idx <= i_ctrl.count)) begin
                n_value = i_lower_value;
            end
        end else if (i_ctrl.pop_head && (w_idx_p1 < i_ctrl.count)) begin
            n_value = i_upper_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign w_sel = (i_ctrl.pop_tail && (w_idx_p1 == i_ctrl.count))
                || (i_ctrl.pop_head && (w_idx == '0));

    assign o_value     = r_value;
    assign o_sel_value = w_sel ? r_value : '0;

endmodule

// File: rtl/core/array_list_shift_insert_remove.sv
// Top level of the ordered word list built from a chain of shifting cells.
//
// Input channel: i_in_valid / o_in_ready carry one command item (command,
// position, data value). Output channel: o_out_valid / i_out_ready carry one
// result item (removed value, status, entry count) for every command.
// All entries live in a row of cells, one word each. An accepted command
// updates every cell in the same cycle, so inserts and head pops shift the
// whole list at once. The removed word is gathered through a two-level OR
// tree over the cells: the group ORs are registered in the middle stage
// with the status and count, and the final OR in the output register.
// Throughput is one item per cycle while the receiver does not stall.
// Failed commands (full, empty or bad position) leave the list unchanged.
// Reset empties the list and drops any item in flight; o_in_ready stays low
// while reset is held. Cell contents are not cleared since only entries below
// the count are ever read.
// When the receiver stalls, the result waits in the output register, one more
// item may sit in the middle stage, and o_in_ready then drops until the
// output register frees up.
`include "array_list_shift_insert_remove_defines.svh"

module array_list_shift_insert_remove (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_command,
    input  logic [alsi_pkg::POS_W-1:0]         i_position,
    input  logic signed [alsi_pkg::DATA_W-1:0] i_data_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [alsi_pkg::DATA_W-1:0] o_removed_value,
    output logic [1:0]                         o_status,
    output logic [alsi_pkg::ENTRY_W-1:0]       o_entry_count
);

    logic [alsi_pkg::CNT_W-1:0]         r_count;
    logic [alsi_pkg::CNT_W-1:0]         n_count;
    alsi_pkg::t_status                  n_status;
    alsi_pkg::t_cell_ctrl               w_ctrl;
    logic                               w_accept;
    logic                               w_s1_move;
    logic                               w_full;
    logic                               w_empty;
    logic                               w_fail_cmd;
    logic                               w_out_empty;

    logic signed [alsi_pkg::DATA_W-1:0] w_value [alsi_pkg::DEPTH];
    logic signed [alsi_pkg::DATA_W-1:0] w_sel   [alsi_pkg::DEPTH];
    logic signed [alsi_pkg::DATA_W-1:0] n_grp   [alsi_pkg::NUM_GRP];
    logic signed [alsi_pkg::DATA_W-1:0] r_grp   [alsi_pkg::NUM_GRP];
    logic signed [alsi_pkg::DATA_W-1:0] w_removed;

    logic                               r_s1_valid;
    alsi_pkg::t_status                  r_s1_status;
    logic [alsi_pkg::CNT_W-1:0]         r_s1_count;

    logic                               r_out_valid;
    logic signed [alsi_pkg::DATA_W-1:0] r_out_removed;
    alsi_pkg::t_status                  r_out_status;
    logic [alsi_pkg::CNT_W-1:0]         r_out_count;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || !r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = (r_count == alsi_pkg::CNT_W'(alsi_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_status        = alsi_pkg::ST_OK;
        n_count         = r_count;
        w_ctrl          = '0;
        w_ctrl.count    = r_count;
        w_ctrl.data     = i_data_value;
        unique case (alsi_pkg::t_command'(i_command))
            alsi_pkg::CMD_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = alsi_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                    w_ctrl.pos = r_count;
                    n_count    = r_count + alsi_pkg::CNT_W'(1);
                end
            end
            alsi_pkg::CMD_INS_HEAD: begin
                if (w_full) begin
                    n_status = alsi_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                    w_ctrl.pos = '0;
                    n_count    = r_count + alsi_pkg::CNT_W'(1);
                end
            end
            alsi_pkg::CMD_INS_POS: begin
                if (w_full) begin
                    n_status = alsi_pkg::ST_FULL;
                end else if (alsi_pkg::CMP_W'(i_position) > alsi_pkg::CMP_W'(r_count)) begin
                    n_status = alsi_pkg::ST_BADPOS;
                end else begin
                    w_ctrl.ins = 1'b1;
                    w_ctrl.pos = alsi_pkg::CNT_W'(i_position);
                    n_count    = r_count + alsi_pkg::CNT_W'(1);
                end
            end
            alsi_pkg::CMD_POP_TAIL: begin
                if (w_empty) begin
                    n_status = alsi_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.pop_tail = 1'b1;
                    n_count         = r_count - alsi_pkg::CNT_W'(1);
                end
            end
            alsi_pkg::CMD_POP_HEAD: begin
                if (w_empty) begin
                    n_status = alsi_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.pop_head = 1'b1;
                    n_count         = r_count - alsi_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_ctrl.ins      = 1'b0;
            w_ctrl.pop_head = 1'b0;
            w_ctrl.pop_tail = 1'b0;
        end
    end

    for (genvar g = 0; g < alsi_pkg::DEPTH; g++) begin : g_cell
        logic signed [alsi_pkg::DATA_W-1:0] w_lower;
        logic signed [alsi_pkg::DATA_W-1:0] w_upper;
        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_value[g-1];
        end
        if (g == alsi_pkg::DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_value[g+1];
        end
        alsi_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (alsi_pkg::IDX_W'(g)),
            .i_ctrl        (w_ctrl),
            .i_lower_value (w_lower),
            .i_upper_value (w_upper),
            .o_value       (w_value[g]),
            .o_sel_value   (w_sel[g])
        );
    end

    always_comb begin
        for (int g = 0; g < alsi_pkg::NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < alsi_pkg::GRP_SZ; k++) begin
                if (g * alsi_pkg::GRP_SZ + k < alsi_pkg::DEPTH) begin
                    n_grp[g] = n_grp[g] | w_sel[g * alsi_pkg::GRP_SZ + k];
                end
            end
        end
    end

    always_comb begin
        w_removed = '0;
        for (int g = 0; g < alsi_pkg::NUM_GRP; g++) begin
            w_removed = w_removed | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= n_status;
            r_s1_count  <= n_count;
            r_grp       <= n_grp;
        end
        if (w_s1_move) begin
            r_out_removed <= w_removed;
            r_out_status  <= r_s1_status;
            r_out_count   <= r_s1_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_status        = r_out_status;
    assign o_entry_count   = alsi_pkg::ENTRY_W'(r_out_count);

    assign w_fail_cmd  = w_accept && (n_status != alsi_pkg::ST_OK);
    assign w_out_empty = r_out_valid && (r_out_status == alsi_pkg::ST_EMPTY);

    `ALSI_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, !(r_count > w_ctrl.count) && !w_full || w_full)
    `ALSI_ASSERT_NEXT(a_fail_keeps_count, i_clk, i_rst_n, w_fail_cmd, r_count == $past(r_count))
    `ALSI_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, w_out_empty, r_out_removed == '0)
    `ALSI_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, w_accept, r_s1_valid)

endmodule
